>>> rtl/mspwm_pkg.sv
// Shared constants, types and codes of the multichannel slot PWM.
package mspwm_pkg;

    localparam int SLOTS    = 64;
    localparam int CHANNELS = 16;

    localparam int FUNC_W    = 2;
    localparam int CH_W      = 4;
    localparam int START_W   = 6;
    localparam int LEN_W     = 7;
    localparam int PINS_W    = 16;
    localparam int SLOTNOW_W = 6;
    localparam int EDGE_W    = 2 * PINS_W;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SUM_W  = SLOT_W + 1;

    localparam logic [PINS_W-1:0] CHAN_MASK = PINS_W'((33'd1 << CHANNELS) - 33'd1);

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD   = 2'd0,
        FN_APPLY = 2'd1,
        FN_TICK  = 2'd2,
        FN_OFF   = 2'd3
    } t_func;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic rd_edge_start;
        logic edge_wr_start;
        logic edge_wr_stop;
        logic mark_step;
        logic apply_commit;
        logic tick_commit;
        logic all_off;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic  accepted;
        t_func func;
        logic  add_ok;
        logic  edge_need;
        logic  mark_done;
        logic  out_free;
    } t_sts;

endpackage

>>> rtl/mspwm_if.sv
// Valid/ready channel interfaces for the input items and the results.
interface mspwm_in_if
    import mspwm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [CH_W-1:0]    channel;
    logic [START_W-1:0] start_slot;
    logic [LEN_W-1:0]   pulse_len;

    modport source (output valid, output func, output channel, output start_slot,
                    output pulse_len, input ready);
    modport sink   (input valid, input func, input channel, input start_slot,
                    input pulse_len, output ready);
endinterface

interface mspwm_out_if
    import mspwm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [PINS_W-1:0]    pins;
    logic [SLOTNOW_W-1:0] slot_now;

    modport source (output valid, output pins, output slot_now, input ready);
    modport sink   (input valid, input pins, input slot_now, output ready);
endinterface

>>> rtl/mspwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mspwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/mspwm_ctrl.sv
// Controller state machine that sequences each transaction through the datapath.
module mspwm_ctrl
    import mspwm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DEC    = 8'b0000_0010,
        ST_EDGE_A = 8'b0000_0100,
        ST_EDGE_B = 8'b0000_1000,
        ST_MARK   = 8'b0001_0000,
        ST_APPLY  = 8'b0010_0000,
        ST_TICK   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (i_sts.accepted) begin
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                case (i_sts.func)
                    FN_ADD: begin
                        if (!i_sts.add_ok) begin
                            n_state = ST_DONE;
                        end else if (i_sts.edge_need) begin
                            cmd.rd_edge_start = 1'b1;
                            n_state = ST_EDGE_A;
                        end else begin
                            n_state = ST_MARK;
                        end
                    end
                    FN_APPLY: n_state = ST_APPLY;
                    FN_TICK:  n_state = ST_TICK;
                    FN_OFF: begin
                        cmd.all_off = 1'b1;
                        n_state = ST_DONE;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_EDGE_A: begin
                cmd.edge_wr_start = 1'b1;
                n_state = ST_EDGE_B;
            end
            ST_EDGE_B: begin
                cmd.edge_wr_stop = 1'b1;
                n_state = ST_MARK;
            end
            ST_MARK: begin
                if (i_sts.mark_done) begin
                    n_state = ST_DONE;
                end else begin
                    cmd.mark_step = 1'b1;
                end
            end
            ST_APPLY: begin
                cmd.apply_commit = 1'b1;
                n_state = ST_DONE;
            end
            ST_TICK: begin
                cmd.tick_commit = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;
endmodule

>>> rtl/mspwm_dp.sv
// Datapath: edge banks, pulse-mask table, slot counter, pin levels and result register.
module mspwm_dp
    import mspwm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_sts         o_sts,
    mspwm_in_if.sink     in_if,
    mspwm_out_if.source  out_if
);
    // Transaction fields captured at acceptance.
    t_func              r_func;
    logic [PINS_W-1:0]  r_bit;
    logic [SLOT_W-1:0]  r_start;
    logic [SLOT_W-1:0]  r_stop;
    logic               r_add_ok;
    logic               r_edge_need;

    // Mask marking walk.
    logic [SLOT_W-1:0]  r_idx;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_wr_pend;
    logic [SLOT_W-1:0]  r_wr_idx;

    // Architectural state.
    logic               r_active_is_b;
    logic [SLOT_W-1:0]  r_slot;
    logic [PINS_W-1:0]  r_pins;
    logic [SLOTS-1:0]   r_va;
    logic [SLOTS-1:0]   r_vb;
    logic [SLOTS-1:0]   r_vm;

    // Result register.
    logic                 r_out_valid;
    logic [PINS_W-1:0]    r_out_pins;
    logic [SLOTNOW_W-1:0] r_out_slot;

    logic                 accepted;
    logic [SLOT_W-1:0]    in_start;
    logic [CNT_W-1:0]     in_len;
    logic [SUM_W-1:0]     stop_sum;
    logic [SLOT_W-1:0]    in_stop;
    logic                 in_ok;

    logic [EDGE_W-1:0]    rd_a;
    logic [EDGE_W-1:0]    rd_b;
    logic [PINS_W-1:0]    rd_m;
    logic [EDGE_W-1:0]    pend_rd;
    logic [EDGE_W-1:0]    act_rd;
    logic [SLOTS-1:0]     pend_v;
    logic [SLOTS-1:0]     act_v;
    logic [EDGE_W-1:0]    pend_old;
    logic [EDGE_W-1:0]    bank_wdata;
    logic [SLOT_W-1:0]    bank_waddr;
    logic [SLOT_W-1:0]    bank_raddr;
    logic                 pend_we;
    logic                 we_a;
    logic                 we_b;
    logic                 mask_we;
    logic [PINS_W-1:0]    mask_wdata;
    logic [SLOT_W-1:0]    mask_raddr;
    logic [EDGE_W-1:0]    tick_word;
    logic [PINS_W-1:0]    apply_pm;
    logic [SLOT_W-1:0]    slot_next;
    logic                 out_free;

    assign accepted = in_if.valid && i_cmd.in_ready;
    assign in_if.ready = i_cmd.in_ready;

    // Decode of an add-pulse request: saturate the length and wrap the stop slot.
    always_comb begin
        in_start = SLOT_W'(in_if.start_slot);
        if (32'(in_if.pulse_len) > SLOTS) begin
            in_len = CNT_W'(SLOTS);
        end else begin
            in_len = CNT_W'(in_if.pulse_len);
        end
        stop_sum = SUM_W'(in_start) + SUM_W'(in_len);
        if (stop_sum >= SUM_W'(SLOTS)) begin
            stop_sum = stop_sum - SUM_W'(SLOTS);
        end
        in_stop = SLOT_W'(stop_sum);
        in_ok   = (in_if.pulse_len != '0) && (32'(in_if.channel) < CHANNELS)
                  && (32'(in_if.start_slot) < SLOTS);
    end

    assign pend_rd  = r_active_is_b ? rd_a : rd_b;
    assign act_rd   = r_active_is_b ? rd_b : rd_a;
    assign pend_v   = r_active_is_b ? r_va : r_vb;
    assign act_v    = r_active_is_b ? r_vb : r_va;

    // Never-written entries read as zero through their valid bits.
    assign pend_old = (i_cmd.edge_wr_start ? pend_v[r_start] : pend_v[r_stop])
                      ? pend_rd : '0;

    always_comb begin
        if (i_cmd.rd_edge_start) begin
            bank_raddr = r_start;
        end else if (i_cmd.edge_wr_start) begin
            bank_raddr = r_stop;
        end else begin
            bank_raddr = r_slot;
        end
    end

    assign pend_we    = i_cmd.edge_wr_start || i_cmd.edge_wr_stop;
    assign we_a       = pend_we && r_active_is_b;
    assign we_b       = pend_we && !r_active_is_b;
    assign bank_waddr = i_cmd.edge_wr_start ? r_start : r_stop;
    assign bank_wdata = i_cmd.edge_wr_start ? (pend_old | {r_bit, {PINS_W{1'b0}}})
                                            : (pend_old | {{PINS_W{1'b0}}, r_bit});

    assign mask_we    = i_cmd.mark_step && r_wr_pend;
    assign mask_wdata = (r_vm[r_wr_idx] ? rd_m : '0) | r_bit;
    assign mask_raddr = i_cmd.mark_step ? r_idx : r_slot;

    assign tick_word  = act_v[r_slot] ? act_rd : '0;
    assign apply_pm   = r_vm[r_slot] ? rd_m : '0;
    assign slot_next  = (32'(r_slot) + 1 >= SLOTS) ? '0 : r_slot + SLOT_W'(1);

    mspwm_ram #(.WIDTH(EDGE_W), .DEPTH(SLOTS)) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (bank_waddr),
        .i_wdata (bank_wdata),
        .i_raddr (bank_raddr),
        .o_rdata (rd_a)
    );

    mspwm_ram #(.WIDTH(EDGE_W), .DEPTH(SLOTS)) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (bank_waddr),
        .i_wdata (bank_wdata),
        .i_raddr (bank_raddr),
        .o_rdata (rd_b)
    );

    mspwm_ram #(.WIDTH(PINS_W), .DEPTH(SLOTS)) u_mask (
        .i_clk   (i_clk),
        .i_we    (mask_we),
        .i_waddr (r_wr_idx),
        .i_wdata (mask_wdata),
        .i_raddr (mask_raddr),
        .o_rdata (rd_m)
    );

    // Captured fields, the walk index, count and write index, and the result data carry no reset.
    always_ff @(posedge i_clk) begin
        if (accepted) begin
            r_func      <= t_func'(in_if.func);
            r_bit       <= PINS_W'(1) << in_if.channel;
            r_start     <= in_start;
            r_stop      <= in_stop;
            r_add_ok    <= in_ok;
            r_edge_need <= (in_stop != in_start);
            r_idx       <= in_start;
            r_cnt       <= in_len;
            r_wr_idx    <= in_start;
        end else if (i_cmd.mark_step && (r_cnt != '0)) begin
            // Read one entry ahead while the previous one is written back.
            r_wr_idx <= r_idx;
            r_idx    <= (32'(r_idx) + 1 >= SLOTS) ? '0 : r_idx + SLOT_W'(1);
            r_cnt    <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_pins <= r_pins;
            r_out_slot <= SLOTNOW_W'(r_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend     <= 1'b0;
            r_active_is_b <= 1'b0;
            r_slot        <= '0;
            r_pins        <= '0;
            r_va          <= '0;
            r_vb          <= '0;
            r_vm          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accepted) begin
                r_wr_pend <= 1'b0;
            end else if (i_cmd.mark_step) begin
                r_wr_pend <= (r_cnt != '0);
            end
            if (we_a) begin
                r_va[bank_waddr] <= 1'b1;
            end
            if (we_b) begin
                r_vb[bank_waddr] <= 1'b1;
            end
            if (mask_we) begin
                r_vm[r_wr_idx] <= 1'b1;
            end
            if (i_cmd.apply_commit) begin
                // The old active bank becomes pending and starts empty.
                r_active_is_b <= !r_active_is_b;
                if (r_active_is_b) begin
                    r_vb <= '0;
                end else begin
                    r_va <= '0;
                end
                r_vm   <= '0;
                r_pins <= apply_pm & CHAN_MASK;
                r_slot <= slot_next;
            end
            if (i_cmd.tick_commit) begin
                r_pins <= ((r_pins & ~tick_word[PINS_W-1:0]) | tick_word[EDGE_W-1:PINS_W])
                          & CHAN_MASK;
                r_slot <= slot_next;
            end
            if (i_cmd.all_off) begin
                if (r_active_is_b) begin
                    r_vb <= '0;
                end else begin
                    r_va <= '0;
                end
                r_vm   <= '0;
                r_pins <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign out_free = !r_out_valid || out_if.ready;

    assign out_if.valid    = r_out_valid;
    assign out_if.pins     = r_out_pins;
    assign out_if.slot_now = r_out_slot;

    assign o_sts.accepted  = accepted;
    assign o_sts.func      = r_func;
    assign o_sts.add_ok    = r_add_ok;
    assign o_sts.edge_need = r_edge_need;
    assign o_sts.mark_done = (r_cnt == '0) && !r_wr_pend;
    assign o_sts.out_free  = out_free;
endmodule

>>> rtl/multichannel_slot_pwm_unit.sv
// Top level of the multichannel slot PWM: controller plus datapath.
//
// Input channel i_in carries one command per transaction: func (add pulse, apply,
// tick, all off), channel, start_slot and pulse_len. Every command yields exactly
// one result transaction on o_out with the pin levels and the slot counter.
// Commands are processed one at a time; the state machine walks each one
// through two single-port-read edge banks and a pulse-mask RAM.
// An add pulse that adds nothing goes straight to the result; one with edges to
// write writes the start and stop edges and then walks the mask, and a
// full-period pulse (len saturated at 64) writes no edges and only walks the
// mask. The mask walk does one read-modify-write per slot. A new command is
// taken once the result register is loaded and the controller is back in idle.
// Reset clears the pins, slot counter and bank select, and empties all three
// tables at once through per-entry valid bits; no clearing pass is needed.
// If o_out stalls, the finished result waits in its output register while the
// next command is accepted and processed; that command then holds at its end
// until the register frees up.
module multichannel_slot_pwm_unit
    import mspwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mspwm_in_if.sink    i_in,
    mspwm_out_if.source o_out
);
    t_cmd cmd;
    t_sts sts;

    mspwm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mspwm_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .in_if   (i_in),
        .out_if  (o_out)
    );
endmodule

>>> dv/tb.sv
// Self-checking testbench for multichannel_slot_pwm_unit with a pin-level predictor class.
module tb;
    import mspwm_pkg::*;

    localparam int TOTAL_CMDS   = 1600;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [PINS_W-1:0]    pins;
        logic [SLOTNOW_W-1:0] slot_now;
    } t_pwm_levels;

    // Tracks the edge banks, pulse masks, slot counter and pins, and predicts
    // the levels reported after every command.
    class t_pin_predictor;
        logic [EDGE_W-1:0] edge_words [2][SLOTS];
        logic [PINS_W-1:0] pulse_masks [SLOTS];
        bit                active_sel;
        int                slot_cnt;
        logic [PINS_W-1:0] pin_levels;
        t_pwm_levels       expected_levels [$];
        int                mismatches;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                edge_words[0][i] = '0;
                edge_words[1][i] = '0;
                pulse_masks[i]   = '0;
            end
            active_sel = 1'b0;
            slot_cnt   = 0;
            pin_levels = '0;
            mismatches = 0;
        endfunction

        function void step_slot();
            slot_cnt = (slot_cnt + 1 >= SLOTS) ? 0 : slot_cnt + 1;
        endfunction

        // Clear bits act before set bits within one edge word.
        function void play_word(logic [EDGE_W-1:0] word);
            pin_levels = (pin_levels & ~word[PINS_W-1:0]) | word[EDGE_W-1:PINS_W];
            pin_levels = pin_levels & CHAN_MASK;
        endfunction

        function void add_pulse(int ch, int start, int len);
            logic [PINS_W-1:0] bit_mask;
            int stop;
            int idx;
            if (len == 0 || ch >= CHANNELS || start >= SLOTS) return;
            if (len > SLOTS) len = SLOTS;
            bit_mask = PINS_W'(1) << ch;
            stop = start + len;
            if (stop >= SLOTS) stop -= SLOTS;
            // A full-period pulse has its edges on one slot and writes none.
            if (stop != start) begin
                edge_words[!active_sel][start] |= {bit_mask, {PINS_W{1'b0}}};
                edge_words[!active_sel][stop]  |= {{PINS_W{1'b0}}, bit_mask};
            end
            idx = start;
            for (int i = 0; i < len; i++) begin
                pulse_masks[idx] |= bit_mask;
                idx = (idx + 1 >= SLOTS) ? 0 : idx + 1;
            end
        endfunction

        function void note_command(t_func f, logic [CH_W-1:0] ch, logic [START_W-1:0] st,
                                   logic [LEN_W-1:0] len);
            logic [PINS_W-1:0] pm;
            logic [EDGE_W-1:0] word;
            case (f)
                FN_ADD: begin
                    add_pulse(int'(ch), int'(st), int'(len));
                end
                FN_APPLY: begin
                    active_sel = !active_sel;
                    pm = pulse_masks[slot_cnt];
                    play_word({pm, ~pm});
                    step_slot();
                    for (int i = 0; i < SLOTS; i++) begin
                        edge_words[!active_sel][i] = '0;
                        pulse_masks[i] = '0;
                    end
                end
                FN_TICK: begin
                    word = edge_words[active_sel][slot_cnt];
                    step_slot();
                    play_word(word);
                end
                default: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        edge_words[active_sel][i] = '0;
                        pulse_masks[i] = '0;
                    end
                    pin_levels = '0;
                end
            endcase
            expected_levels.push_back('{pins: pin_levels, slot_now: SLOTNOW_W'(slot_cnt)});
        endfunction

        function void check_levels(logic [PINS_W-1:0] pins, logic [SLOTNOW_W-1:0] slot_now);
            t_pwm_levels exp_lv;
            if (expected_levels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: unexpected result pins=%h slot_now=%0d", pins, slot_now);
                return;
            end
            exp_lv = expected_levels.pop_front();
            if (pins !== exp_lv.pins) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: pins expected %h, got %h", exp_lv.pins, pins);
            end
            if (slot_now !== exp_lv.slot_now) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: slot_now expected %0d, got %0d",
                             exp_lv.slot_now, slot_now);
            end
        endfunction

        function int outstanding();
            return expected_levels.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mspwm_in_if  cmd_if ();
    mspwm_out_if lvl_if ();

    multichannel_slot_pwm_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (lvl_if)
    );

    t_pin_predictor pred = new();

    int cmds_sent = 0;
    bit tx_eager  = 1'b0;
    bit hold_req  = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Both handshakes are sampled at the edge, before any driver updates land.
    always @(posedge i_clk) begin
        if (cmd_if.valid && cmd_if.ready)
            pred.note_command(t_func'(cmd_if.func), cmd_if.channel, cmd_if.start_slot,
                              cmd_if.pulse_len);
        if (lvl_if.valid && lvl_if.ready)
            pred.check_levels(lvl_if.pins, lvl_if.slot_now);
    end

    function automatic int pick_gap(bit eager);
        int r;
        if (eager) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side: random stalls, eager stretches, and one long hold-off on request.
    initial begin
        int stall_left;
        int mode_left;
        bit rx_eager;
        stall_left = 0;
        mode_left  = $urandom_range(50, 300);
        rx_eager   = 1'b0;
        lvl_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                rx_eager  = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 300);
            end else begin
                mode_left--;
            end
            if (hold_req) begin
                hold_req = 1'b0;
                lvl_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_left > 0) begin
                lvl_if.ready <= 1'b0;
                stall_left--;
            end else begin
                lvl_if.ready <= 1'b1;
                stall_left = pick_gap(rx_eager);
            end
        end
    end

    task automatic send_command(t_func f, logic [CH_W-1:0] ch, logic [START_W-1:0] st,
                                logic [LEN_W-1:0] len);
        int gap;
        gap = pick_gap(tx_eager);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.func       <= f;
        cmd_if.channel    <= ch;
        cmd_if.start_slot <= st;
        cmd_if.pulse_len  <= len;
        do @(posedge i_clk); while (!cmd_if.ready);
        cmds_sent++;
    endtask

    // Other commands carry random channel, slot and length fields that must be ignored.
    task automatic send_plain(t_func f);
        send_command(f, CH_W'($urandom), START_W'($urandom), LEN_W'($urandom));
    endtask

    task automatic send_random_pulse();
        int r;
        logic [LEN_W-1:0] len;
        r = $urandom_range(0, 99);
        if (r < 5)       len = '0;
        else if (r < 10) len = LEN_W'($urandom_range(SLOTS + 1, 127));
        else if (r < 25) len = LEN_W'($urandom_range(SLOTS - 4, SLOTS));
        else             len = LEN_W'($urandom_range(1, 40));
        send_command(FN_ADD, CH_W'($urandom_range(0, CHANNELS - 1)),
                     START_W'($urandom_range(0, SLOTS - 1)), len);
    endtask

    task automatic wait_for_results();
        while (pred.outstanding() != 0) @(posedge i_clk);
    endtask

    initial begin
        int kind;
        bit hold_done;
        bit drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        i_rst_n           <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.func       <= FN_TICK;
        cmd_if.channel    <= '0;
        cmd_if.start_slot <= '0;
        cmd_if.pulse_len  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, zero length, saturated and full-period pulses,
        // wrap past the last slot, and a set and clear that coincide in one word.
        send_command(FN_TICK, 4'd0, 6'd0, 7'd0);
        send_command(FN_ADD, 4'd0, 6'd0, 7'd1);
        send_command(FN_ADD, 4'd15, 6'd63, 7'd64);
        send_command(FN_ADD, 4'd7, 6'd10, 7'd0);
        send_command(FN_ADD, 4'd3, 6'd60, 7'd127);
        send_command(FN_ADD, 4'd5, 6'd62, 7'd5);
        send_command(FN_ADD, 4'd5, 6'd3, 7'd2);
        send_command(FN_ADD, 4'd9, 6'd42, 7'd21);
        send_command(FN_APPLY, 4'd0, 6'd0, 7'd0);
        repeat (8) send_command(FN_TICK, 4'd15, 6'd63, 7'd127);
        send_command(FN_OFF, 4'd0, 6'd0, 7'd0);
        send_command(FN_TICK, 4'd0, 6'd0, 7'd0);
        send_command(FN_APPLY, 4'd0, 6'd0, 7'd0);
        send_command(FN_TICK, 4'd0, 6'd0, 7'd0);

        while (cmds_sent < TOTAL_CMDS) begin
            if (!hold_done && cmds_sent > 400) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (!drain_done && cmds_sent > 900) begin
                drain_done = 1'b1;
                cmd_if.valid <= 1'b0;
                wait_for_results();
            end
            tx_eager = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                // A pattern: some pulses, usually applied, then played out by ticks.
                repeat ($urandom_range(1, 6)) send_random_pulse();
                if ($urandom_range(0, 9) != 0) send_plain(FN_APPLY);
                repeat ($urandom_range(1, 70)) begin
                    if ($urandom_range(0, 49) == 0) send_plain(FN_OFF);
                    else send_plain(FN_TICK);
                end
            end else if (kind < 90) begin
                send_plain(FN_OFF);
                repeat ($urandom_range(1, 20)) send_plain(FN_TICK);
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    if ($urandom_range(0, 3) == 0) send_random_pulse();
                    else send_plain(t_func'($urandom_range(1, 3)));
                end
            end
        end
        cmd_if.valid <= 1'b0;

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pred.mismatches == 0 && pred.outstanding() == 0) begin
            $display("** multichannel_slot_pwm_unit: PASSED **");
        end else begin
            $display("** multichannel_slot_pwm_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("ERROR: timeout");
        $display("** multichannel_slot_pwm_unit: FAILED **");
        $finish;
    end

endmodule
